>>> hw/rtl/hcd_pkg.sv
// ----------------------------------------------------------------------------
// hcd_pkg
// Types, codes and the CRC-32 byte update shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hcd_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam int          MAX_W         = 13;
    localparam logic [12:0] MAX_RESET     = 13'd2064;
    localparam int          TAIL_DEPTH    = 4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_START = 3'd1;
    localparam logic [2:0] ST_ESC_FLAG = 3'd2;
    localparam logic [2:0] ST_ESC_ESC  = 3'd3;
    localparam logic [2:0] ST_SHORT    = 3'd4;
    localparam logic [2:0] ST_LONG     = 3'd5;
    localparam logic [2:0] ST_CRC      = 3'd6;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_FRAME   = 4'b0010,
        MODE_ESC     = 4'b0100,
        MODE_DISCARD = 4'b1000
    } mode_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic       frame_end;
    } result_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hcd_in_stage.sv
// ----------------------------------------------------------------------------
// hcd_in_stage
// Input register: holds one received word until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic       take,
    output logic            item_valid,
    output logic [7:0]      item_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hcd_core.sv
// ----------------------------------------------------------------------------
// hcd_core
// Frame state, unescape, four-word holding line, CRC-32 and status decode.
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_core #(
    parameter int COUNT_BITS = 13
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [hcd_pkg::MAX_W-1:0] cfg_wr_data,
    input  wire logic                     item_valid,
    input  wire logic [7:0]               item_byte,
    input  wire logic                     out_ready,
    output logic                          take,
    output logic                          res_valid,
    output hcd_pkg::result_t              res
);
    import hcd_pkg::*;

    localparam int CMP_W = (COUNT_BITS > MAX_W) ? COUNT_BITS : MAX_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_MIN = COUNT_BITS'(TAIL_DEPTH);

    mode_t                 mode_reg, mode_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [31:0]           crc_reg, crc_next;
    logic [MAX_W-1:0]      max_reg;
    logic [7:0]            tail_reg [TAIL_DEPTH];
    logic                  shift;
    logic [7:0]            plain;
    logic [31:0]           got;
    logic                  too_long;
    logic [2:0]            close_st;

    assign take  = item_valid && out_ready;
    assign plain = (mode_reg == MODE_ESC) ? (item_byte ^ ESC_XOR) : item_byte;
    assign got   = {tail_reg[3], tail_reg[2], tail_reg[1], tail_reg[0]};
    assign too_long = (cnt_reg == COUNT_MAX) ||
                      (CMP_W'(cnt_reg) > CMP_W'(max_reg));

    always_comb begin
        if (cnt_reg < COUNT_MIN) begin
            close_st = ST_SHORT;
        end else if (too_long) begin
            close_st = ST_LONG;
        end else if ((crc_reg ^ CRC_INIT) == got) begin
            close_st = ST_OK;
        end else begin
            close_st = ST_CRC;
        end
    end

    always_comb begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        crc_next  = crc_reg;
        shift     = 1'b0;
        res_valid = 1'b0;
        res       = '{kind: KIND_STATUS, data_byte: 8'd0, status: ST_OK, frame_end: 1'b1};
        if (take) begin
            case (mode_reg)
                MODE_IDLE: begin
                    if (item_byte == FLAG_BYTE) begin
                        mode_next = MODE_FRAME;
                        cnt_next  = '0;
                        crc_next  = CRC_INIT;
                    end else begin
                        mode_next  = MODE_DISCARD;
                        res_valid  = 1'b1;
                        res.status = ST_NO_START;
                    end
                end
                MODE_DISCARD: begin
                    if (item_byte == FLAG_BYTE) begin
                        mode_next = MODE_FRAME;
                        cnt_next  = '0;
                        crc_next  = CRC_INIT;
                    end
                end
                MODE_FRAME, MODE_ESC: begin
                    if (item_byte == FLAG_BYTE) begin
                        res_valid = 1'b1;
                        if (mode_reg == MODE_ESC) begin
                            mode_next  = MODE_DISCARD;
                            res.status = ST_ESC_FLAG;
                        end else begin
                            mode_next  = MODE_IDLE;
                            res.status = close_st;
                        end
                    end else if (item_byte == ESC_BYTE) begin
                        if (mode_reg == MODE_ESC) begin
                            mode_next  = MODE_DISCARD;
                            res_valid  = 1'b1;
                            res.status = ST_ESC_ESC;
                        end else begin
                            mode_next = MODE_ESC;
                        end
                    end else begin
                        mode_next = MODE_FRAME;
                        shift     = 1'b1;
                        if (cnt_reg != COUNT_MAX) begin
                            cnt_next = cnt_reg + COUNT_ONE;
                        end
                        if (cnt_reg >= COUNT_MIN) begin
                            crc_next  = crc32_byte(crc_reg, tail_reg[0]);
                            res_valid = 1'b1;
                            res       = '{kind: KIND_DATA, data_byte: tail_reg[0],
                                          status: ST_OK, frame_end: 1'b0};
                        end
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            cnt_reg  <= '0;
            crc_reg  <= CRC_INIT;
            max_reg  <= MAX_RESET;
        end else begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            crc_reg  <= crc_next;
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
        end
    end

    // advance the holding line, oldest word at entry 0
    always_ff @(posedge aclk) begin
        if (shift) begin
            for (int i = 0; i < TAIL_DEPTH - 1; i++) begin
                tail_reg[i] <= tail_reg[i+1];
            end
            tail_reg[TAIL_DEPTH-1] <= plain;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/hcd_out_stage.sv
// ----------------------------------------------------------------------------
// hcd_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             res_valid,
    input  wire hcd_pkg::result_t res,
    output logic                  out_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output hcd_pkg::result_t      m_res
);
    import hcd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_ready  = !valid_reg || m_ready;
    assign valid_next = out_ready ? res_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hdlc_crc32_deframer.sv
// ----------------------------------------------------------------------------
// hdlc_crc32_deframer
// Flag-delimited, byte-stuffed frame receiver with CRC-32 trailer check.
// Words pass u_in, then u_core; any result is registered in u_out.
// Throughput: one input word per cycle, unless m_ready stalls the output stage.
// Reset: synchronous, active low; returns to hunting for a flag, limit 2064.
// The holding line is not reset; its entries are read only once written.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlc_crc32_deframer #(
    parameter int COUNT_BITS = 13
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [12:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [7:0]       m_data_byte,
    output logic [2:0]       m_status,
    output logic             m_frame_end
);
    import hcd_pkg::*;

    logic       item_valid;
    logic [7:0] item_byte;
    logic       take;
    logic       out_ready;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    hcd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .take       (take),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    hcd_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_byte   (item_byte),
        .out_ready   (out_ready),
        .take        (take),
        .res_valid   (res_valid),
        .res         (res)
    );

    hcd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_kind      = m_res.kind;
    assign m_data_byte = m_res.data_byte;
    assign m_status    = m_res.status;
    assign m_frame_end = m_res.frame_end;

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while both stages are full");

    a_payload_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_DATA) |-> (m_status == ST_OK && !m_frame_end))
        else $error("payload word carries status fields");

    a_status_marks_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_STATUS) |-> (m_frame_end && m_data_byte == 8'd0))
        else $error("status word without frame end");

endmodule

`default_nettype wire
